/* sv/assert_macros.svh */
// assertion macros shared by the median filter sources
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SWM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("median filter check failed");

// next-cycle implication, disabled while reset is asserted
`define SWM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("median filter check failed");

`endif

/* sv/swm_pkg.sv */
// package: widths, constants and control types of the median filter
`timescale 1ns / 1ps
package swm_pkg;

  localparam int WINDOW = 20;
  localparam int DATA_W = 16;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // ranks of the lower and upper middle entries, equal for an odd window
  localparam logic [CNT_W-1:0] RANK_LO = CNT_W'((WINDOW - 1) / 2);
  localparam logic [CNT_W-1:0] RANK_HI = CNT_W'(WINDOW / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } swm_state_t;

  typedef struct packed {
    logic write;
    logic scan_step;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } swm_sts_t;

endpackage

/* sv/swm_if.sv */
// valid/ready channel interfaces for samples and medians
`timescale 1ns / 1ps
interface swm_in_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

/* sv/sliding_window_median_filter.sv */
// top level: sliding-window median filter over unsigned Q8.8 samples
//
//   channel  dir  payload           width  role
//   in_ch    in   sample            16     one force sample per transfer
//   out_ch   out  median            16     median of the window after the write
//
// each sample is written into the window, then the rank scan walks the store
// entry by entry, then the result is loaded into the output register.
// reset (rst_n low, synchronous) clears the window, the pointer and all handshakes.
// a new sample is taken while the previous result still waits in the output register;
// the block stalls only when a second result is ready and the first is not taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sliding_window_median_filter import swm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  swm_in_if.sink   in_ch,
  swm_out_if.source out_ch
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_ch.sample),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_median (out_ch.median)
  );

  `SWM_ASSERT_NXT(a_busy_after_write, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SWM_ASSERT_IMP(a_write_not_in_scan, clk, rst_n, cmd.write, !cmd.scan_step && !cmd.load_out)
  `SWM_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_out, !out_ch.valid || out_ch.ready)
  `SWM_ASSERT_NXT(a_load_shows_result, clk, rst_n, cmd.load_out, out_ch.valid)

endmodule

/* sv/swm_ctrl.sv */
// controller: sequences write, rank scan and result load
`timescale 1ns / 1ps
module swm_ctrl import swm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  swm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.write = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait here while the previous result is still unclaimed
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/swm_dp.sv */
// datapath: circular window, rank scan over entries, output register
`timescale 1ns / 1ps
module swm_dp import swm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  swm_cmd_t          cmd,
  output swm_sts_t          sts,
  input  logic [DATA_W-1:0] in_sample,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_median
);

  logic [DATA_W-1:0] win_r [WINDOW];
  logic [IDX_W-1:0]  wp_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_median_r;

  logic [DATA_W-1:0] cand;
  logic [WINDOW-1:0] lt_mask, le_mask;
  logic [CNT_W-1:0]  lt_cnt, le_cnt;
  logic [DATA_W:0]   mid_sum;

  // window store and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_r[k] <= '0;
      end
      wp_r <= '0;
    end else if (cmd.write) begin
      win_r[wp_r] <= in_sample;
      wp_r        <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
    end
  end

  // rank of the candidate entry against the whole window
  always_comb begin
    cand = win_r[idx_r];
    for (int k = 0; k < WINDOW; k++) begin
      lt_mask[k] = win_r[k] <  cand;
      le_mask[k] = win_r[k] <= cand;
    end
    lt_cnt = CNT_W'($countones(lt_mask));
    le_cnt = CNT_W'($countones(le_mask));
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    // the candidate holds sorted positions lt_cnt .. le_cnt-1
    if (lt_cnt <= RANK_LO && RANK_LO < le_cnt) begin
      lo_nxt = cand;
    end
    if (lt_cnt <= RANK_HI && RANK_HI < le_cnt) begin
      hi_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.write) begin
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  // output register, freed by a transfer on the result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_median_r <= mid_sum[DATA_W:1];
    end
  end

  assign sts.scan_last = (idx_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_median    = out_median_r;

endmodule
